// ----- rtl/pulse_interval_power_meter_defines.svh -----
// Assertion macros used by pipm_dp.
`ifndef PULSE_INTERVAL_POWER_METER_DEFINES_SVH
`define PULSE_INTERVAL_POWER_METER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PIPM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pipm assertion failed");

// Next-cycle implication, checked out of reset.
`define PIPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pipm assertion failed");

`endif

// ----- rtl/pipm_pkg.sv -----
package pipm_pkg;

  localparam logic [31:0] HOUR_US      = 32'd3600000000;
  localparam logic [9:0]  WATTS_PER_KW = 10'd1000;
  localparam logic [22:0] POWER_MAX    = 23'h7FFFFF;
  localparam logic [15:0] MC_RESET     = 16'd600;

  localparam logic KIND_PULSE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // divider operand select
  localparam logic DIV_SEL_HOUR  = 1'b0;
  localparam logic DIV_SEL_WATTS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_Q_GO,
    S_Q_WAIT,
    S_MUL,
    S_W_GO,
    S_W_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_sel;
    logic load_quot;
    logic load_prod;
    logic load_watts;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic have_pulse;
    logic kind;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/pulse_interval_power_meter.sv -----
// Pulse-interval power meter.
// Input channel (in_valid / in_stall): kind 0 is a meter pulse, kind 1 a
// query; timestamp_us is the event time in microseconds. A pulse returns
// nothing; a query returns one transaction on the output channel
// (out_valid / out_stall) with pulse_count, power_watts and below_flag.
// Config channel (cfg_valid / cfg_ready): writes meter_constant; cfg_ready
// is always high. Write it only while the block is idle.
// The first pulse and any item before it skip the divisions. Any later item
// runs two 32-step divisions on one shared radix-2 divider (hour / interval,
// then product / meter_constant) plus setup; in_stall is high from accept
// until the block is back in idle, so the next item waits until this one is
// done. The divider sets the rate.
// A finished result sits in an output register; the block takes the next
// item while it waits, and a query holds in its last step until that
// register is free when the receiver stalls.
// Reset (rst, synchronous): meter_constant returns to 600, pulse count,
// stored power and last timestamp to zero, no result pending.
module pulse_interval_power_meter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [31:0] timestamp_us,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] meter_constant,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pulse_count,
  output logic [22:0] power_watts,
  output logic        below_flag
);

  pipm_pkg::cmd_t cmd;
  pipm_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  pipm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pipm_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .kind           (kind),
    .timestamp_us   (timestamp_us),
    .cfg_valid      (cfg_valid && cfg_ready),
    .meter_constant (meter_constant),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pulse_count    (pulse_count),
    .power_watts    (power_watts),
    .below_flag     (below_flag)
  );

endmodule

// ----- rtl/pipm_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// A divisor of zero yields an all-ones quotient.
module pipm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem;
  logic [31:0] dq;
  logic [31:0] dsr;
  logic [4:0]  cnt;
  logic        busy;

  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    shifted = {rem, dq[31]};
    diff    = shifted - {1'b0, dsr};
    ge      = shifted >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : shifted[31:0];
      dq  <= {dq[30:0], ge};
    end
  end

  assign quotient = dq;

endmodule

// ----- rtl/pipm_ctrl.sv -----
module pipm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  pipm_pkg::sts_t  sts,
  output pipm_pkg::cmd_t  cmd
);

  pipm_pkg::state_t state;
  pipm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pipm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pipm_pkg::S_IDLE: begin
        if (in_valid) begin
          // first pulse and queries before any pulse skip the math
          state_next = sts.have_pulse ? pipm_pkg::S_Q_GO : pipm_pkg::S_DONE;
        end
      end
      pipm_pkg::S_Q_GO:   state_next = pipm_pkg::S_Q_WAIT;
      pipm_pkg::S_Q_WAIT: begin
        if (sts.div_done) begin
          state_next = pipm_pkg::S_MUL;
        end
      end
      pipm_pkg::S_MUL:    state_next = pipm_pkg::S_W_GO;
      pipm_pkg::S_W_GO:   state_next = pipm_pkg::S_W_WAIT;
      pipm_pkg::S_W_WAIT: begin
        if (sts.div_done) begin
          state_next = pipm_pkg::S_DONE;
        end
      end
      pipm_pkg::S_DONE: begin
        if (sts.kind == pipm_pkg::KIND_PULSE || sts.out_free) begin
          state_next = pipm_pkg::S_IDLE;
        end
      end
      default: state_next = pipm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != pipm_pkg::S_IDLE);
    case (state)
      pipm_pkg::S_IDLE:   cmd.accept = in_valid;
      pipm_pkg::S_Q_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = pipm_pkg::DIV_SEL_HOUR;
      end
      pipm_pkg::S_Q_WAIT: cmd.load_quot = sts.div_done;
      pipm_pkg::S_MUL:    cmd.load_prod = 1'b1;
      pipm_pkg::S_W_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = pipm_pkg::DIV_SEL_WATTS;
      end
      pipm_pkg::S_W_WAIT: cmd.load_watts = sts.div_done;
      pipm_pkg::S_DONE: begin
        cmd.commit = (sts.kind == pipm_pkg::KIND_PULSE) || sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/pipm_dp.sv -----
`include "pulse_interval_power_meter_defines.svh"

module pipm_dp (
  input  logic            clk,
  input  logic            rst,
  input  pipm_pkg::cmd_t  cmd,
  output pipm_pkg::sts_t  sts,
  input  logic            kind,
  input  logic [31:0]     timestamp_us,
  input  logic            cfg_valid,
  input  logic [15:0]     meter_constant,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [31:0]     pulse_count,
  output logic [22:0]     power_watts,
  output logic            below_flag
);

  logic [15:0] divisor_cfg;
  logic [31:0] last_pulse_time;
  logic        have_pulse;
  logic [22:0] stored_power;
  logic [31:0] pulse_counter;

  logic        item_kind;
  logic [31:0] item_time;
  logic [31:0] quot;
  logic [31:0] prod;
  logic [22:0] watts;

  logic        div_start;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [31:0] div_quot;

  logic [41:0] prod_full;
  logic [15:0] mc_eff;
  logic [22:0] est;
  logic        out_free;

  always_comb begin
    mc_eff    = (divisor_cfg == 16'd0) ? 16'd1 : divisor_cfg;
    prod_full = {10'd0, quot} * {32'd0, pipm_pkg::WATTS_PER_KW};
    if (cmd.div_sel == pipm_pkg::DIV_SEL_HOUR) begin
      div_dividend = pipm_pkg::HOUR_US;
      div_divisor  = item_time - last_pulse_time;
    end else begin
      div_dividend = prod;
      div_divisor  = {16'd0, mc_eff};
    end
    div_start = cmd.div_start;
    est       = have_pulse ? watts : stored_power;
    out_free  = !out_valid || !out_stall;
  end

  pipm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind <= kind;
      item_time <= timestamp_us;
    end
    if (cmd.load_quot) begin
      quot <= div_quot;
    end
    if (cmd.load_prod) begin
      prod <= (prod_full[41:32] != 10'd0) ? 32'hFFFFFFFF : prod_full[31:0];
    end
    if (cmd.load_watts) begin
      watts <= (div_quot > {9'd0, pipm_pkg::POWER_MAX}) ? pipm_pkg::POWER_MAX
                                                        : div_quot[22:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor_cfg     <= pipm_pkg::MC_RESET;
      last_pulse_time <= '0;
      have_pulse      <= 1'b0;
      stored_power    <= '0;
      pulse_counter   <= '0;
    end else begin
      if (cfg_valid) begin
        divisor_cfg <= meter_constant;
      end
      if (cmd.commit && item_kind == pipm_pkg::KIND_PULSE) begin
        if (have_pulse) begin
          stored_power <= watts;
        end
        pulse_counter   <= pulse_counter + 32'd1;
        last_pulse_time <= item_time;
        have_pulse      <= 1'b1;
      end
    end
  end

  // result register: holds one transaction while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && item_kind == pipm_pkg::KIND_QUERY) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && item_kind == pipm_pkg::KIND_QUERY) begin
      pulse_count <= pulse_counter;
      if (est < stored_power) begin
        power_watts <= est;
        below_flag  <= 1'b1;
      end else begin
        power_watts <= stored_power;
        below_flag  <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.have_pulse = have_pulse;
    sts.kind       = item_kind;
    sts.div_done   = div_done;
    sts.out_free   = out_free;
  end

  `PIPM_ASSERT_NOW(a_out_load_free, clk, rst, cmd.commit && item_kind == pipm_pkg::KIND_QUERY, !out_valid || !out_stall)
  `PIPM_ASSERT_NEXT(a_pulse_counts, clk, rst, cmd.commit && item_kind == pipm_pkg::KIND_PULSE, have_pulse && pulse_counter == $past(pulse_counter) + 32'd1)
  `PIPM_ASSERT_NEXT(a_query_keeps_state, clk, rst, cmd.commit && item_kind == pipm_pkg::KIND_QUERY, $stable(pulse_counter) && $stable(stored_power) && out_valid)

endmodule

// ----- dv/tb_pulse_interval_power_meter.sv -----
module tb_pulse_interval_power_meter;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] cnt;
    logic [22:0] pw;
    logic        flag;
  } reading_t;

  // directed stimulus; chk marks rows whose reading is typed in
  typedef struct packed {
    logic        k;
    logic [31:0] ts;
    logic        chk;
    logic [31:0] cnt;
    logic [22:0] pw;
    logic        flag;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = pipm_pkg::KIND_PULSE;
  logic [31:0] timestamp_us = 32'd0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] meter_constant = pipm_pkg::MC_RESET;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] pulse_count;
  logic [22:0] power_watts;
  logic        below_flag;

  pulse_interval_power_meter dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .timestamp_us  (timestamp_us),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .meter_constant(meter_constant),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pulse_count   (pulse_count),
    .power_watts   (power_watts),
    .below_flag    (below_flag)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #30_000_000;
    $display("pulse_interval_power_meter: mismatch");
    $finish;
  end

  // shadow of the meter state
  logic [15:0] mc_shadow = pipm_pkg::MC_RESET;
  logic [31:0] last_ts = 32'd0;
  logic        seen_pulse = 1'b0;
  logic [22:0] power_held = 23'd0;
  logic [31:0] pulses = 32'd0;

  reading_t readings_due[$];
  int       mismatches = 0;
  int       send_idle_pct = 26;
  int       recv_idle_pct = 74;

  function automatic logic [22:0] watts_for_interval(input logic [31:0] span,
                                                     input logic [15:0] mc);
    logic [63:0] quot, prod, dv, w;
    quot = (span == 32'd0) ? 64'hFFFF_FFFF
                           : {32'd0, pipm_pkg::HOUR_US} / {32'd0, span};
    prod = quot * {54'd0, pipm_pkg::WATTS_PER_KW};
    if (prod > 64'hFFFF_FFFF) prod = 64'hFFFF_FFFF;
    dv = (mc == 16'd0) ? 64'd1 : {48'd0, mc};
    w = prod / dv;
    if (w > {41'd0, pipm_pkg::POWER_MAX}) w = {41'd0, pipm_pkg::POWER_MAX};
    return w[22:0];
  endfunction

  // advances the shadow state; returns 1 when the item yields a reading
  function automatic logic meter_step(input logic k, input logic [31:0] ts,
                                      output reading_t r);
    logic [22:0] est;
    r = '0;
    if (k == pipm_pkg::KIND_PULSE) begin
      if (seen_pulse) power_held = watts_for_interval(ts - last_ts, mc_shadow);
      pulses = pulses + 32'd1;
      last_ts = ts;
      seen_pulse = 1'b1;
      return 1'b0;
    end
    est = seen_pulse ? watts_for_interval(ts - last_ts, mc_shadow) : power_held;
    r.cnt = pulses;
    r.flag = est < power_held;
    r.pw = r.flag ? est : power_held;
    return 1'b1;
  endfunction

  task automatic apply_item(input logic k, input logic [31:0] ts, input logic chk,
                            input reading_t typed);
    reading_t calc;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    timestamp_us <= ts;
    do @(posedge clk); while (in_stall);
    if (meter_step(k, ts, calc)) readings_due.push_back(chk ? typed : calc);
  endtask

  // hold off input until every reading is back, then let the divider finish
  task automatic quiesce(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic program_constant(input logic [15:0] v);
    cfg_valid <= 1'b1;
    meter_constant <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mc_shadow = v;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (readings_due.size() == 0) begin
        $display("%0t unexpected reading: expected none, got count %0d power %0d below %0d",
                 $time, pulse_count, power_watts, below_flag);
        mismatches++;
      end else begin
        want = readings_due.pop_front();
        if (pulse_count !== want.cnt) begin
          $display("%0t pulse_count: expected %0d, got %0d", $time, want.cnt, pulse_count);
          mismatches++;
        end
        if (power_watts !== want.pw) begin
          $display("%0t power_watts: expected %0d, got %0d", $time, want.pw, power_watts);
          mismatches++;
        end
        if (below_flag !== want.flag) begin
          $display("%0t below_flag: expected %0d, got %0d", $time, want.flag, below_flag);
          mismatches++;
        end
      end
    end
  end

  // meter constant is 600 out of reset
  row_t dir_rows [15] = '{
    '{pipm_pkg::KIND_QUERY, 32'd0,         1'b1, 32'd0, 23'd0,       1'b0}, // before any pulse
    '{pipm_pkg::KIND_PULSE, 32'd1000,      1'b0, 32'd0, 23'd0,       1'b0}, // first pulse
    '{pipm_pkg::KIND_QUERY, 32'd1000,      1'b1, 32'd1, 23'd0,       1'b0},
    '{pipm_pkg::KIND_PULSE, 32'd1000,      1'b0, 32'd0, 23'd0,       1'b0}, // zero interval
    '{pipm_pkg::KIND_QUERY, 32'd1000,      1'b1, 32'd2, 23'd7158278, 1'b0},
    '{pipm_pkg::KIND_QUERY, 32'd3601000,   1'b0, 32'd0, 23'd0,       1'b0}, // decayed estimate
    '{pipm_pkg::KIND_PULSE, 32'd3604600,   1'b0, 32'd0, 23'd0,       1'b0},
    '{pipm_pkg::KIND_PULSE, 32'hFFFF_FFF0, 1'b0, 32'd0, 23'd0,       1'b0},
    '{pipm_pkg::KIND_PULSE, 32'h0000_0001, 1'b0, 32'd0, 23'd0,       1'b0}, // wide product
    '{pipm_pkg::KIND_QUERY, 32'h0000_0001, 1'b0, 32'd0, 23'd0,       1'b0},
    '{pipm_pkg::KIND_QUERY, 32'h8000_0001, 1'b0, 32'd0, 23'd0,       1'b0},
    '{pipm_pkg::KIND_PULSE, 32'h8000_0000, 1'b0, 32'd0, 23'd0,       1'b0},
    '{pipm_pkg::KIND_PULSE, 32'h7FFF_FFFF, 1'b0, 32'd0, 23'd0,       1'b0}, // max interval
    '{pipm_pkg::KIND_QUERY, 32'h7FFF_FFFF, 1'b1, 32'd7, 23'd0,       1'b0},
    '{pipm_pkg::KIND_QUERY, 32'hFFFF_FFFF, 1'b0, 32'd0, 23'd0,       1'b0}
  };

  initial begin
    reading_t    tv;
    logic [31:0] ts, step, now_us;
    logic        k;
    logic [15:0] mc;
    int          seg, n, i;
    now_us = 32'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < 15; i++) begin
      tv.cnt = dir_rows[i].cnt;
      tv.pw = dir_rows[i].pw;
      tv.flag = dir_rows[i].flag;
      apply_item(dir_rows[i].k, dir_rows[i].ts, dir_rows[i].chk, tv);
    end
    now_us = 32'hFFFF_FFFF;

    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: mc = 16'd1;
        1: mc = 16'hFFFF;
        2: mc = 16'd0;
        4: mc = pipm_pkg::MC_RESET;
        default: mc = 16'($urandom_range(2, 65534));
      endcase
      quiesce(150);
      program_constant(mc);
      case (seg / 2)
        0: begin send_idle_pct = 26; recv_idle_pct = 74; end
        1: begin send_idle_pct = 74; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (n = 0; n < 225; n++) begin
        if ($urandom_range(0, 99) < 10) begin
          ts = $urandom;
        end else begin
          case ($urandom_range(0, 4))
            0: step = $urandom_range(0, 20);
            1: step = $urandom_range(21, 5000);
            2: step = $urandom_range(5001, 4_000_000);
            3: step = $urandom_range(4_000_001, 600_000_000);
            default: step = $urandom;
          endcase
          ts = now_us + step;
        end
        k = ($urandom_range(0, 99) < 40) ? pipm_pkg::KIND_QUERY : pipm_pkg::KIND_PULSE;
        if (k == pipm_pkg::KIND_PULSE) now_us = ts;
        apply_item(k, ts, 1'b0, '0);
        if ($urandom_range(0, 99) == 0) quiesce(0);
      end
    end

    quiesce(150);
    if (mismatches == 0) begin
      $display("pulse_interval_power_meter: match");
    end else begin
      $display("pulse_interval_power_meter: mismatch");
    end
    $finish;
  end

endmodule
